>>> rtl/oid_der_pkg.sv
package oid_der_pkg;

  typedef enum logic [2:0] {
    PH_TAG      = 3'd0,
    PH_LEN      = 3'd1,
    PH_LEN_LONG = 3'd2,
    PH_FIRST    = 3'd3,
    PH_ARCS     = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_TAG  = 3'd1,
    ERR_LEN  = 3'd2,
    ERR_OVF  = 3'd3,
    ERR_PAST = 3'd4
  } err_t;

  localparam logic [7:0]  OID_TAG     = 8'h06;
  localparam logic [7:0]  FIRST_DIV   = 8'd40;
  localparam logic [15:0] DIV40_MUL   = 16'd205;
  localparam int          DIV40_SHIFT = 13;
  localparam int          ERR_W       = 3;
  localparam int          FIFO_DEPTH  = 4;

endpackage

>>> rtl/oid_der_parser.sv
module oid_der_parser #(
  parameter int MAX_LENGTH_BYTES = 4,
  parameter int ARC_WIDTH        = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [7:0]             data_byte,
  output logic [1:0]             push,
  output logic [ARC_WIDTH+3:0]   ent0,
  output logic [ARC_WIDTH+3:0]   ent1
);

  localparam int LW  = 8 * MAX_LENGTH_BYTES;
  localparam int LBW = $clog2(MAX_LENGTH_BYTES + 1);

  oid_der_pkg::phase_t  phase, phase_next;
  logic [LW-1:0]        content, content_next;
  logic [LBW-1:0]       len_left, len_left_next;
  logic [ARC_WIDTH-1:0] acc, acc_next;

  logic [LW-1:0]        content_dec;
  logic [LW-1:0]        content_shift;
  logic [LBW-1:0]       len_left_dec;
  logic [ARC_WIDTH-1:0] acc_new;
  logic [15:0]          prod;
  logic [2:0]           quot;
  logic [7:0]           remd;

  assign content_dec   = content - LW'(1);
  assign content_shift = LW'({content, data_byte});
  assign len_left_dec  = len_left - LBW'(1);
  assign acc_new       = {acc[ARC_WIDTH-8:0], data_byte[6:0]};
  assign prod          = {8'd0, data_byte} * oid_der_pkg::DIV40_MUL;
  assign quot          = prod[15:oid_der_pkg::DIV40_SHIFT];
  assign remd          = data_byte - 8'({5'd0, quot} * oid_der_pkg::FIRST_DIV);

  always_comb begin
    phase_next    = phase;
    content_next  = content;
    len_left_next = len_left;
    acc_next      = acc;
    push          = 2'd0;
    ent0          = '0;
    ent1          = '0;
    if (take) begin
      case (phase)
        oid_der_pkg::PH_TAG: begin
          if (data_byte != oid_der_pkg::OID_TAG) begin
            push = 2'd1;
            ent0 = {ARC_WIDTH'(0), 1'b0, oid_der_pkg::ERR_TAG};
          end else begin
            phase_next = oid_der_pkg::PH_LEN;
          end
        end
        oid_der_pkg::PH_LEN: begin
          if (!data_byte[7]) begin
            if (data_byte == 8'd0) begin
              push       = 2'd1;
              ent0       = {ARC_WIDTH'(0), 1'b0, oid_der_pkg::ERR_LEN};
              phase_next = oid_der_pkg::PH_TAG;
            end else begin
              content_next = LW'(data_byte);
              phase_next   = oid_der_pkg::PH_FIRST;
            end
          end else if (data_byte[6:0] == 7'd0 ||
                       data_byte[6:0] > 7'(MAX_LENGTH_BYTES)) begin
            push       = 2'd1;
            ent0       = {ARC_WIDTH'(0), 1'b0, oid_der_pkg::ERR_LEN};
            phase_next = oid_der_pkg::PH_TAG;
          end else begin
            content_next  = '0;
            len_left_next = LBW'(data_byte[6:0]);
            phase_next    = oid_der_pkg::PH_LEN_LONG;
          end
        end
        oid_der_pkg::PH_LEN_LONG: begin
          content_next  = content_shift;
          len_left_next = len_left_dec;
          if (len_left_dec == '0) begin
            if (content_shift == '0) begin
              push         = 2'd1;
              ent0         = {ARC_WIDTH'(0), 1'b0, oid_der_pkg::ERR_LEN};
              phase_next   = oid_der_pkg::PH_TAG;
              content_next = '0;
            end else begin
              phase_next = oid_der_pkg::PH_FIRST;
            end
          end
        end
        oid_der_pkg::PH_FIRST: begin
          push         = 2'd2;
          content_next = content_dec;
          acc_next     = '0;
          ent0         = {ARC_WIDTH'(quot), 1'b0, oid_der_pkg::ERR_NONE};
          if (content_dec == '0) begin
            ent1       = {ARC_WIDTH'(remd), 1'b1, oid_der_pkg::ERR_NONE};
            phase_next = oid_der_pkg::PH_TAG;
          end else begin
            ent1       = {ARC_WIDTH'(remd), 1'b0, oid_der_pkg::ERR_NONE};
            phase_next = oid_der_pkg::PH_ARCS;
          end
        end
        oid_der_pkg::PH_ARCS: begin
          if (acc[ARC_WIDTH-1:ARC_WIDTH-7] != 7'd0) begin
            push         = 2'd1;
            ent0         = {ARC_WIDTH'(0), 1'b0, oid_der_pkg::ERR_OVF};
            phase_next   = oid_der_pkg::PH_TAG;
            content_next = '0;
            acc_next     = '0;
          end else if (data_byte[7]) begin
            if (content_dec == '0) begin
              push         = 2'd1;
              ent0         = {ARC_WIDTH'(0), 1'b0, oid_der_pkg::ERR_PAST};
              phase_next   = oid_der_pkg::PH_TAG;
              content_next = '0;
              acc_next     = '0;
            end else begin
              content_next = content_dec;
              acc_next     = acc_new;
            end
          end else begin
            push         = 2'd1;
            content_next = content_dec;
            acc_next     = '0;
            if (content_dec == '0) begin
              ent0       = {acc_new, 1'b1, oid_der_pkg::ERR_NONE};
              phase_next = oid_der_pkg::PH_TAG;
            end else begin
              ent0 = {acc_new, 1'b0, oid_der_pkg::ERR_NONE};
            end
          end
        end
        default: begin
          phase_next    = oid_der_pkg::PH_TAG;
          content_next  = '0;
          len_left_next = '0;
          acc_next      = '0;
        end
      endcase
      if (phase_next == oid_der_pkg::PH_TAG) begin
        len_left_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= oid_der_pkg::PH_TAG;
      content  <= '0;
      len_left <= '0;
      acc      <= '0;
    end else begin
      phase    <= phase_next;
      content  <= content_next;
      len_left <= len_left_next;
      acc      <= acc_next;
    end
  end

endmodule

>>> rtl/oid_der_fifo.sv
module oid_der_fifo #(
  parameter int EW = 36
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push,
  input  logic [EW-1:0] ent0,
  input  logic [EW-1:0] ent1,
  input  logic          pop,
  output logic          not_empty,
  output logic          no_room,
  output logic [EW-1:0] head
);

  localparam int AW = $clog2(oid_der_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(oid_der_pkg::FIFO_DEPTH + 1);

  logic [EW-1:0] slots [oid_der_pkg::FIFO_DEPTH];
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [CW-1:0] count, count_next;

  assign not_empty   = (count != '0);
  assign no_room     = (count > CW'(oid_der_pkg::FIFO_DEPTH - 2));
  assign head        = slots[rd_ptr];
  assign wr_ptr_next = wr_ptr + AW'(push);
  assign rd_ptr_next = rd_ptr + AW'(pop);
  assign count_next  = count + CW'(push) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push != 2'd0) begin
      slots[wr_ptr] <= ent0;
    end
    if (push == 2'd2) begin
      slots[wr_ptr + AW'(1)] <= ent1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

>>> rtl/oid_der_decoder_top.sv
// Decodes a DER object identifier one byte per transfer: a tag of 0x06, a
// definite length in short form or in long form of up to MAX_LENGTH_BYTES
// bytes, then the content, whose first byte yields two arcs and whose later
// bytes form base-128 arcs. The parser state is registered as each byte is
// taken, so a byte can be accepted every cycle while in_stall is low; the
// first content byte gives two results and all others at most one. Results
// queue in a four-entry buffer, and input is stalled only while fewer than
// two entries are free. An error result carries a zero arc and no end mark,
// and the decoder then waits for a new tag.
module oid_der_decoder_top #(
  parameter int MAX_LENGTH_BYTES = 4,
  parameter int ARC_WIDTH        = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ARC_WIDTH-1:0] arc_value,
  output logic                 end_of_oid,
  output logic [2:0]           error_code
);

  localparam int EW = ARC_WIDTH + 1 + oid_der_pkg::ERR_W;

  logic          take;
  logic          pop;
  logic          no_room;
  logic [1:0]    push;
  logic [EW-1:0] ent0;
  logic [EW-1:0] ent1;
  logic [EW-1:0] head;

  assign in_stall = no_room;
  assign take     = in_valid & ~no_room;
  assign pop      = out_valid & ~out_stall;

  oid_der_parser #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES),
    .ARC_WIDTH(ARC_WIDTH)
  ) u_parser (
    .clk(clk),
    .rst(rst),
    .take(take),
    .data_byte(data_byte),
    .push(push),
    .ent0(ent0),
    .ent1(ent1)
  );

  oid_der_fifo #(
    .EW(EW)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .ent0(ent0),
    .ent1(ent1),
    .pop(pop),
    .not_empty(out_valid),
    .no_room(no_room),
    .head(head)
  );

  assign arc_value  = head[EW-1:oid_der_pkg::ERR_W+1];
  assign end_of_oid = head[oid_der_pkg::ERR_W];
  assign error_code = head[oid_der_pkg::ERR_W-1:0];

endmodule

>>> rtl/oid_der_checker.sv
module oid_der_assertions #(
  parameter int ARC_WIDTH = 32
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [ARC_WIDTH-1:0] arc_value,
  input logic                 end_of_oid,
  input logic [2:0]           error_code
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(arc_value) &&
      $stable(end_of_oid) && $stable(error_code))
    else $error("Stalled result changed or was withdrawn.");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != oid_der_pkg::ERR_NONE |->
      arc_value == '0 && !end_of_oid)
    else $error("Error result carries an arc or an end mark.");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("Input stalled while no result is queued.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("Results present straight after reset.");

endmodule

bind oid_der_decoder_top oid_der_assertions #(.ARC_WIDTH(ARC_WIDTH)) u_checker (
  .clk(clk),
  .rst(rst),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .arc_value(arc_value),
  .end_of_oid(end_of_oid),
  .error_code(error_code)
);
